// File: rtl/isme_pkg.sv
package isme_pkg;

	localparam int OPERAND_DEPTH_DEF = 64;
	localparam int LOCAL_DEPTH_DEF   = 64;
	localparam int IP_BITS_DEF       = 16;

	localparam int MODE_W   = 6;
	localparam int WORD_W   = 64;
	localparam int STATUS_W = 4;
	localparam int NIP_W    = 16;
	localparam int DEPTH_W  = 7;
	localparam int OUT_W    = 96;

	typedef enum logic [MODE_W-1:0] {
		OP_PUSH   = 6'd0,
		OP_POP    = 6'd1,
		OP_STORE  = 6'd2,
		OP_LOAD   = 6'd3,
		OP_DUP    = 6'd4,
		OP_SWAP   = 6'd5,
		OP_ADD    = 6'd6,
		OP_SUB    = 6'd7,
		OP_MUL    = 6'd8,
		OP_DIV    = 6'd9,
		OP_MOD    = 6'd10,
		OP_INC    = 6'd11,
		OP_DEC    = 6'd12,
		OP_AND    = 6'd13,
		OP_OR     = 6'd14,
		OP_XOR    = 6'd15,
		OP_NOT    = 6'd16,
		OP_SHL    = 6'd17,
		OP_SHR    = 6'd18,
		OP_EQ     = 6'd19,
		OP_NE     = 6'd20,
		OP_GT     = 6'd21,
		OP_NGT    = 6'd22,
		OP_LT     = 6'd23,
		OP_NLT    = 6'd24,
		OP_GTE    = 6'd25,
		OP_LTE    = 6'd26,
		OP_JMP    = 6'd27,
		OP_JMPIF  = 6'd28,
		OP_JMPIFN = 6'd29,
		OP_RET    = 6'd30,
		OP_PRINT  = 6'd31,
		OP_SCAN   = 6'd32,
		OP_SIZEOF = 6'd33,
		OP_HALT   = 6'd34,
		OP_DUMPST = 6'd35,
		OP_DUMPSK = 6'd36,
		OP_POW    = 6'd37
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 4'd0,
		STS_FULL    = 4'd1,
		STS_EMPTY   = 4'd2,
		STS_OVER    = 4'd3,
		STS_UNDER   = 4'd4,
		STS_FEW     = 4'd5,
		STS_ILLEGAL = 4'd6,
		STS_UNIMPL  = 4'd7,
		STS_DIVZERO = 4'd8
	} sts_t;

	typedef enum logic [1:0] {
		MD_MUL = 2'd0,
		MD_DIV = 2'd1,
		MD_MOD = 2'd2
	} md_op_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RDB,
		S_RDA,
		S_EXEC,
		S_MD,
		S_WB2
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic latch_b;
		logic rd_second;
		logic start_md;
		logic commit;
		logic wb2;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_md;
		logic is_swap;
		logic md_done;
		logic out_free;
	} stat_t;

endpackage

// File: rtl/isme_ram.sv
module isme_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/isme_mdu.sv
module isme_mdu (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  isme_pkg::md_op_t      op,
	input  logic [63:0]           a,
	input  logic [63:0]           b,
	output logic                  done,
	output logic [63:0]           result
);

	isme_pkg::md_op_t op_q;
	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [64:0] rem_q;
	logic [63:0] acc_q;
	logic [63:0] res_q;
	logic [63:0] prod_s1;
	logic        qneg_q;
	logic        rneg_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod_w;
	logic [64:0] rem_sh;
	logic [64:0] diff;
	logic        last;

	// low 64 bits of the product from three 32x32 partial products
	assign mul_a  = (cnt_q == 7'd2) ? x_q[63:32] : x_q[31:0];
	assign mul_b  = (cnt_q == 7'd1) ? y_q[63:32] : y_q[31:0];
	assign prod_w = mul_a * mul_b;

	assign rem_sh = {rem_q[63:0], x_q[63]};
	assign diff   = rem_sh - {1'b0, y_q};
	assign last   = (op_q == isme_pkg::MD_MUL) ? (cnt_q == 7'd3) : (cnt_q == 7'd64);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= op;
			rem_q  <= '0;
			qneg_q <= a[63] ^ b[63];
			rneg_q <= a[63];
			if (op == isme_pkg::MD_MUL) begin
				x_q <= a;
				y_q <= b;
			end else begin
				x_q <= a[63] ? -a : a;
				y_q <= b[63] ? -b : b;
			end
		end else if (busy_q) begin
			prod_s1 <= prod_w;
			if (op_q == isme_pkg::MD_MUL) begin
				case (cnt_q)
					7'd1: acc_q <= prod_s1;
					7'd2: acc_q <= acc_q + {prod_s1[31:0], 32'd0};
					7'd3: res_q <= acc_q + {prod_s1[31:0], 32'd0};
					default: ;
				endcase
			end else if (!cnt_q[6]) begin
				// restoring step, one quotient bit per cycle
				if (!diff[64]) begin
					rem_q <= diff;
					x_q   <= {x_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					x_q   <= {x_q[62:0], 1'b0};
				end
			end else if (op_q == isme_pkg::MD_DIV) begin
				res_q <= qneg_q ? -x_q : x_q;
			end else begin
				res_q <= rneg_q ? -rem_q[63:0] : rem_q[63:0];
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: rtl/isme_ctrl.sv
module isme_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  isme_pkg::stat_t   stat,
	output isme_pkg::cmd_t    cmd
);

	isme_pkg::state_t state_q;
	isme_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isme_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			isme_pkg::S_CLEAR: begin
				if (stat.clr_last) state_nx = isme_pkg::S_IDLE;
			end
			isme_pkg::S_IDLE: begin
				if (in_valid) state_nx = isme_pkg::S_RDB;
			end
			isme_pkg::S_RDB: begin
				state_nx = isme_pkg::S_RDA;
			end
			isme_pkg::S_RDA: begin
				state_nx = isme_pkg::S_EXEC;
			end
			isme_pkg::S_EXEC: begin
				if (stat.need_md) begin
					state_nx = isme_pkg::S_MD;
				end else if (stat.out_free) begin
					state_nx = stat.is_swap ? isme_pkg::S_WB2 : isme_pkg::S_IDLE;
				end
			end
			isme_pkg::S_MD: begin
				if (stat.md_done && stat.out_free) state_nx = isme_pkg::S_IDLE;
			end
			isme_pkg::S_WB2: begin
				state_nx = isme_pkg::S_IDLE;
			end
			default: state_nx = isme_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			isme_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			isme_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			isme_pkg::S_RDB: ;
			isme_pkg::S_RDA: begin
				cmd.latch_b   = 1'b1;
				cmd.rd_second = 1'b1;
			end
			isme_pkg::S_EXEC: begin
				cmd.rd_second = 1'b1;
				cmd.start_md  = stat.need_md;
				cmd.commit    = !stat.need_md && stat.out_free;
			end
			isme_pkg::S_MD: begin
				cmd.rd_second = 1'b1;
				cmd.commit    = stat.md_done && stat.out_free;
			end
			isme_pkg::S_WB2: begin
				cmd.wb2 = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/isme_dp.sv
module isme_dp #(
	parameter int OPERAND_DEPTH = isme_pkg::OPERAND_DEPTH_DEF,
	parameter int LOCAL_DEPTH   = isme_pkg::LOCAL_DEPTH_DEF,
	parameter int IP_BITS       = isme_pkg::IP_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [isme_pkg::MODE_W-1:0]       in_mode,
	input  logic [isme_pkg::WORD_W-1:0]       in_operand,
	input  isme_pkg::cmd_t                    cmd,
	output isme_pkg::stat_t                   stat,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [isme_pkg::STATUS_W-1:0]     out_status,
	output logic [isme_pkg::NIP_W-1:0]        out_next_ip,
	output logic [isme_pkg::WORD_W-1:0]       out_print_value,
	output logic                              out_print_valid,
	output logic                              out_halted,
	output logic [isme_pkg::DEPTH_W-1:0]      out_depth
);

	localparam int SIDX = $clog2(OPERAND_DEPTH);
	localparam int TW   = $clog2(OPERAND_DEPTH + 1);
	localparam int LIDX = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
	localparam int CW   = $clog2(LOCAL_DEPTH + 1);

	logic [isme_pkg::MODE_W-1:0] mode_q;
	logic [63:0]                 opnd_q;
	logic [63:0]                 b_q;
	logic [63:0]                 a_q;
	logic [TW-1:0]               top_q;
	logic [CW-1:0]               lcnt_q;
	logic [IP_BITS-1:0]          ip_q;
	logic                        run_q;
	logic [LIDX-1:0]             clr_q;

	logic [63:0] s_rd;
	logic [63:0] l_rd;
	logic [63:0] md_res;
	logic        md_done;

	logic [TW-1:0]   tm1;
	logic [TW-1:0]   tm2;
	logic [SIDX-1:0] s_raddr;
	logic            s_we;
	logic [SIDX-1:0] s_waddr;
	logic [63:0]     s_wdata;
	logic            l_we;
	logic [LIDX-1:0] l_waddr;
	logic [63:0]     l_wdata;

	isme_pkg::op_t    op;
	isme_pkg::sts_t   st;
	isme_pkg::md_op_t md_op;
	logic [63:0]      alu;
	logic signed [63:0] sra;
	logic [63:0]      res;
	logic             full;
	logic             emp;
	logic             few;
	logic             in_rng;
	logic             need_md;
	logic             is_swap;
	logic             swr;
	logic [SIDX-1:0]  saddr;
	logic [63:0]      sdata;
	logic             lwr;
	logic [TW-1:0]    ntop;
	logic [CW-1:0]    nlcnt;
	logic [IP_BITS-1:0] nip;
	logic             nrun;
	logic [63:0]      pv;
	logic             pval;

	logic             ov_q;

	assign op     = isme_pkg::op_t'(mode_q);
	assign tm1    = top_q - TW'(1);
	assign tm2    = top_q - TW'(2);
	assign full   = (top_q == TW'(OPERAND_DEPTH));
	assign emp    = (top_q == '0);
	assign few    = (top_q < TW'(2));
	assign in_rng = (opnd_q < 64'(LOCAL_DEPTH));

	assign s_raddr = cmd.rd_second ? tm2[SIDX-1:0] : tm1[SIDX-1:0];

	isme_ram #(.WIDTH(64), .DEPTH(OPERAND_DEPTH), .AW(SIDX)) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rd)
	);

	isme_ram #(.WIDTH(64), .DEPTH(LOCAL_DEPTH), .AW(LIDX)) u_local (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (opnd_q[LIDX-1:0]),
		.rdata (l_rd)
	);

	always_comb begin
		case (op)
			isme_pkg::OP_DIV: md_op = isme_pkg::MD_DIV;
			isme_pkg::OP_MOD: md_op = isme_pkg::MD_MOD;
			default:          md_op = isme_pkg::MD_MUL;
		endcase
	end

	isme_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_md),
		.op     (md_op),
		.a      (s_rd),
		.b      (b_q),
		.done   (md_done),
		.result (md_res)
	);

	// arithmetic shift kept apart so the sign fill survives the select below
	assign sra = $signed(s_rd) >>> b_q[5:0];

	// second operand comes straight from the stack read port, top from b_q
	always_comb begin
		alu = '0;
		case (op)
			isme_pkg::OP_ADD: alu = s_rd + b_q;
			isme_pkg::OP_SUB: alu = s_rd - b_q;
			isme_pkg::OP_AND: alu = s_rd & b_q;
			isme_pkg::OP_OR:  alu = s_rd | b_q;
			isme_pkg::OP_XOR: alu = s_rd ^ b_q;
			isme_pkg::OP_SHL: alu = (b_q[63:6] != '0) ? '0 : (s_rd << b_q[5:0]);
			isme_pkg::OP_SHR: alu = (b_q[63:6] != '0) ? {64{s_rd[63]}} : sra;
			isme_pkg::OP_EQ:  alu = 64'($signed(s_rd[31:0]) == $signed(b_q[31:0]));
			isme_pkg::OP_NE:  alu = 64'($signed(s_rd[31:0]) != $signed(b_q[31:0]));
			isme_pkg::OP_GT:  alu = 64'($signed(s_rd[31:0]) >  $signed(b_q[31:0]));
			isme_pkg::OP_NGT: alu = 64'(!($signed(s_rd[31:0]) > $signed(b_q[31:0])));
			isme_pkg::OP_LT:  alu = 64'($signed(s_rd[31:0]) <  $signed(b_q[31:0]));
			isme_pkg::OP_NLT: alu = 64'(!($signed(s_rd[31:0]) < $signed(b_q[31:0])));
			isme_pkg::OP_GTE: alu = 64'($signed(s_rd[31:0]) >= $signed(b_q[31:0]));
			isme_pkg::OP_LTE: alu = 64'($signed(s_rd[31:0]) <= $signed(b_q[31:0]));
			isme_pkg::OP_MUL,
			isme_pkg::OP_DIV,
			isme_pkg::OP_MOD: alu = md_res;
			default:          alu = '0;
		endcase
	end

	always_comb begin
		case (op)
			isme_pkg::OP_INC: res = b_q + 64'd1;
			isme_pkg::OP_DEC: res = b_q - 64'd1;
			isme_pkg::OP_NOT: res = ~b_q;
			default:          res = 64'd8;
		endcase
	end

	always_comb begin
		st      = isme_pkg::STS_OK;
		need_md = 1'b0;
		is_swap = 1'b0;
		swr     = 1'b0;
		saddr   = top_q[SIDX-1:0];
		sdata   = opnd_q;
		lwr     = 1'b0;
		ntop    = top_q;
		nlcnt   = lcnt_q;
		nip     = ip_q + IP_BITS'(1);
		nrun    = run_q;
		pv      = '0;
		pval    = 1'b0;
		if (run_q) begin
			unique case (op) inside
				isme_pkg::OP_PUSH, isme_pkg::OP_SCAN, isme_pkg::OP_RET, isme_pkg::OP_HALT: begin
					if (full) begin
						st = isme_pkg::STS_FULL;
					end else begin
						swr  = 1'b1;
						ntop = top_q + TW'(1);
						if (op == isme_pkg::OP_HALT) nrun = 1'b0;
					end
				end
				isme_pkg::OP_POP: begin
					if (emp) st = isme_pkg::STS_EMPTY;
					else ntop = tm1;
				end
				isme_pkg::OP_STORE: begin
					if (lcnt_q >= CW'(LOCAL_DEPTH)) begin
						st = isme_pkg::STS_OVER;
					end else if (emp) begin
						st = isme_pkg::STS_EMPTY;
					end else if (!in_rng) begin
						st = isme_pkg::STS_ILLEGAL;
					end else begin
						lwr   = 1'b1;
						ntop  = tm1;
						nlcnt = lcnt_q + CW'(1);
					end
				end
				isme_pkg::OP_LOAD: begin
					if (lcnt_q == '0) begin
						st = isme_pkg::STS_UNDER;
					end else if (full) begin
						st = isme_pkg::STS_FULL;
					end else if (!in_rng) begin
						st = isme_pkg::STS_ILLEGAL;
					end else begin
						swr   = 1'b1;
						sdata = l_rd;
						ntop  = top_q + TW'(1);
					end
				end
				isme_pkg::OP_DUP: begin
					if (full) begin
						st = isme_pkg::STS_FULL;
					end else if (emp) begin
						st = isme_pkg::STS_EMPTY;
					end else begin
						swr   = 1'b1;
						sdata = b_q;
						ntop  = top_q + TW'(1);
					end
				end
				isme_pkg::OP_SWAP: begin
					if (full) begin
						st = isme_pkg::STS_FULL;
					end else if (few) begin
						st = isme_pkg::STS_FEW;
					end else begin
						swr     = 1'b1;
						saddr   = tm2[SIDX-1:0];
						sdata   = b_q;
						is_swap = 1'b1;
					end
				end
				isme_pkg::OP_INC, isme_pkg::OP_DEC, isme_pkg::OP_NOT, isme_pkg::OP_SIZEOF: begin
					if (emp) begin
						st = isme_pkg::STS_EMPTY;
					end else begin
						swr   = 1'b1;
						saddr = tm1[SIDX-1:0];
						sdata = res;
					end
				end
				isme_pkg::OP_ADD, isme_pkg::OP_SUB, isme_pkg::OP_MUL, isme_pkg::OP_DIV,
				isme_pkg::OP_MOD, isme_pkg::OP_AND, isme_pkg::OP_OR, isme_pkg::OP_XOR,
				isme_pkg::OP_SHL, isme_pkg::OP_SHR, isme_pkg::OP_EQ, isme_pkg::OP_NE,
				isme_pkg::OP_GT, isme_pkg::OP_NGT, isme_pkg::OP_LT, isme_pkg::OP_NLT,
				isme_pkg::OP_GTE, isme_pkg::OP_LTE: begin
					if (few) begin
						st = isme_pkg::STS_FEW;
					end else if ((op == isme_pkg::OP_DIV || op == isme_pkg::OP_MOD)
					             && b_q == '0) begin
						st = isme_pkg::STS_DIVZERO;
					end else begin
						swr     = 1'b1;
						saddr   = tm2[SIDX-1:0];
						sdata   = alu;
						ntop    = tm1;
						need_md = (op == isme_pkg::OP_MUL || op == isme_pkg::OP_DIV
						           || op == isme_pkg::OP_MOD);
					end
				end
				isme_pkg::OP_JMPIF, isme_pkg::OP_JMPIFN: begin
					if (emp) begin
						st = isme_pkg::STS_EMPTY;
					end else if ((b_q != '0) == (op == isme_pkg::OP_JMPIF)) begin
						nip = opnd_q[IP_BITS-1:0];
					end
				end
				isme_pkg::OP_PRINT: begin
					if (emp) begin
						st = isme_pkg::STS_EMPTY;
					end else begin
						pv   = b_q;
						pval = 1'b1;
						ntop = tm1;
					end
				end
				isme_pkg::OP_DUMPST, isme_pkg::OP_DUMPSK: ;
				isme_pkg::OP_JMP, isme_pkg::OP_POW: st = isme_pkg::STS_UNIMPL;
				default: st = isme_pkg::STS_ILLEGAL;
			endcase
		end
		if (!run_q || st != isme_pkg::STS_OK) nip = ip_q;
	end

	assign s_we    = (cmd.commit && swr) || cmd.wb2;
	assign s_waddr = cmd.wb2 ? tm1[SIDX-1:0] : saddr;
	assign s_wdata = cmd.wb2 ? a_q : sdata;

	assign l_we    = cmd.clear || (cmd.commit && lwr);
	assign l_waddr = cmd.clear ? clr_q : opnd_q[LIDX-1:0];
	assign l_wdata = cmd.clear ? '0 : b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= '0;
			lcnt_q <= '0;
			ip_q   <= '0;
			run_q  <= 1'b1;
			clr_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + LIDX'(1);
			if (cmd.commit) begin
				top_q  <= ntop;
				lcnt_q <= nlcnt;
				ip_q   <= nip;
				run_q  <= nrun;
				ov_q   <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			opnd_q <= in_operand;
		end
		if (cmd.latch_b) b_q <= s_rd;
		if (cmd.rd_second) a_q <= s_rd;
		if (cmd.commit) begin
			out_status      <= st;
			out_next_ip     <= isme_pkg::NIP_W'(nip);
			out_print_value <= pv;
			out_print_valid <= pval;
			out_halted      <= !nrun;
			out_depth       <= isme_pkg::DEPTH_W'(ntop);
		end
	end

	assign out_valid     = ov_q;
	assign stat.clr_last = (clr_q == LIDX'(LOCAL_DEPTH - 1));
	assign stat.need_md  = need_md;
	assign stat.is_swap  = is_swap;
	assign stat.md_done  = md_done;
	assign stat.out_free = !ov_q || out_ready;

endmodule

// File: rtl/integer_stack_machine_executor_top.sv
// channel   dir  tdata                                          tuser
// s_axis    in   operand[63:0]                                  mode[5:0]
// m_axis    out  status, next_ip, print_value, halted, depth    print_valid
//
// each instruction is accepted, reads the stack ram twice and executes; swap adds a
// second write-back, and the next is accepted only after that; mul runs through the
// shared 32x32 multiplier, div and mod through the one-bit-per-cycle divider
// after reset the local store is cleared, with s_axis_tready low
// a stalled m_axis holds its word; the next instruction runs up to its commit and waits
module integer_stack_machine_executor_top #(
	parameter int OPERAND_DEPTH = isme_pkg::OPERAND_DEPTH_DEF,
	parameter int LOCAL_DEPTH   = isme_pkg::LOCAL_DEPTH_DEF,
	parameter int IP_BITS       = isme_pkg::IP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [63:0]                   s_axis_tdata,   // operand[63:0]
	input  logic [isme_pkg::MODE_W-1:0]   s_axis_tuser,   // mode[5:0]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// status[3:0], next_ip[19:4], print_value[83:20], halted[84], depth[91:85]
	output logic [isme_pkg::OUT_W-1:0]    m_axis_tdata,
	output logic                          m_axis_tuser    // print_valid
);

	isme_pkg::cmd_t  cmd;
	isme_pkg::stat_t stat;

	logic [isme_pkg::STATUS_W-1:0] status;
	logic [isme_pkg::NIP_W-1:0]    next_ip;
	logic [isme_pkg::WORD_W-1:0]   print_value;
	logic                          print_valid;
	logic                          halted;
	logic [isme_pkg::DEPTH_W-1:0]  depth;

	isme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	isme_dp #(
		.OPERAND_DEPTH (OPERAND_DEPTH),
		.LOCAL_DEPTH   (LOCAL_DEPTH),
		.IP_BITS       (IP_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_mode         (s_axis_tuser),
		.in_operand      (s_axis_tdata),
		.cmd             (cmd),
		.stat            (stat),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.out_status      (status),
		.out_next_ip     (next_ip),
		.out_print_value (print_value),
		.out_print_valid (print_valid),
		.out_halted      (halted),
		.out_depth       (depth)
	);

	assign m_axis_tdata = {4'd0, depth, halted, print_value, next_ip, status};
	assign m_axis_tuser = print_valid;

endmodule
